// File: src/bdsc_pkg.sv
package bdsc_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    // Field and internal widths
    localparam int CFG_W      = 12;                    // configuration register width
    localparam int POS_W      = $clog2(MAX_WIDTH);     // source position counter
    localparam int IDX_W      = $clog2(LINE_DEPTH);    // line buffer address
    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;             // horizontal pair sum
    localparam int TOT_W      = PIX_W + 2;             // four-pixel sum
    localparam int COORD_W    = 10;                    // output row / column
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Register indexes
    localparam logic CFG_SOURCE_WIDTH  = 1'b0;
    localparam logic CFG_SOURCE_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = CFG_W'(352);
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = CFG_W'(288);

    // Line buffer access for one item
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [SUM_W-1:0] wr_data;
    } t_lb_req;

endpackage

// File: src/box_downscale_by_two_unit.sv
// Two-by-two box downscale of an 8-bit gray frame.
//
// Input stream: one source pixel per item in raster order (i_s_tdata[7:0]).
// Output stream: one item per 2x2 block, emitted when the block's last pixel
// (odd row, odd column) arrives. o_m_tdata holds the average, output row and
// output column; o_m_tlast marks the final output pixel of the frame.
// An odd last column or odd last row produces no output.
//
// Frame size comes from the configuration port (index 0 width, index 1
// height); write it only while the block is idle. Sizes above 2048 clamp.
//
// Throughput: one item per cycle while the receiver keeps up. A result passes
// through the registered line buffer read (stage 1) and then the output
// register. Reset returns counters to the frame start and sizes to 352x288;
// the line buffer keeps no reset state, every entry is written on an even
// row before the next odd row reads it. When the receiver stalls, the output
// register and one internal stage absorb results; input is held off only
// once both are full.
module box_downscale_by_two_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [bdsc_pkg::CFG_W-1:0]          i_cfg_data,
    // Input pixel stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [bdsc_pkg::IN_DATA_W-1:0]      i_s_tdata,  // [7:0] pixel_value
    // Output pixel stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] average_value, [17:8] out_row, [27:18] out_column, [31:28] zero
    output logic [bdsc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast   // frame_done
);

    logic [bdsc_pkg::CFG_W-1:0]   r_cfg_w;
    logic [bdsc_pkg::CFG_W-1:0]   r_cfg_h;
    logic [bdsc_pkg::POS_W-1:0]   r_row;
    logic [bdsc_pkg::POS_W-1:0]   r_col;
    logic [bdsc_pkg::PIX_W-1:0]   r_held;

    logic                         r_s1_valid;
    logic [bdsc_pkg::SUM_W-1:0]   r_s1_pair;
    logic [bdsc_pkg::COORD_W-1:0] r_s1_row;
    logic [bdsc_pkg::COORD_W-1:0] r_s1_col;
    logic                         r_s1_done;

    logic                         r_out_valid;
    logic [bdsc_pkg::PIX_W-1:0]   r_out_avg;
    logic [bdsc_pkg::COORD_W-1:0] r_out_row;
    logic [bdsc_pkg::COORD_W-1:0] r_out_col;
    logic                         r_out_done;

    logic [bdsc_pkg::CFG_W-1:0]   w_lim;
    logic [bdsc_pkg::CFG_W-1:0]   h_lim;
    logic [bdsc_pkg::POS_W-1:0]   out_w;
    logic [bdsc_pkg::POS_W-1:0]   out_h;
    logic [bdsc_pkg::IDX_W-1:0]   col_half;
    logic [bdsc_pkg::IDX_W-1:0]   row_half;
    logic                         in_range;
    logic                         is_done;
    logic [bdsc_pkg::PIX_W-1:0]   pix;
    logic [bdsc_pkg::SUM_W-1:0]   pair;
    logic                         accept;
    logic                         out_en;
    logic                         s1_en;
    logic                         col_wrap;
    logic                         row_wrap;
    logic [bdsc_pkg::SUM_W-1:0]   lb_rd_data;
    logic [bdsc_pkg::TOT_W-1:0]   total;
    logic [bdsc_pkg::POS_W-1:0]   n_row;
    logic [bdsc_pkg::POS_W-1:0]   n_col;
    bdsc_pkg::t_lb_req            lb_req;

    // Handshake: output register frees when taken, stage 1 frees when it moves
    assign out_en     = !r_out_valid || i_m_tready;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_s_tready = s1_en;
    assign accept     = i_s_tvalid && s1_en;

    // Clamped frame size and half-size limits
    assign w_lim = (r_cfg_w > bdsc_pkg::CFG_W'(bdsc_pkg::MAX_WIDTH))
                 ? bdsc_pkg::CFG_W'(bdsc_pkg::MAX_WIDTH) : r_cfg_w;
    assign h_lim = (r_cfg_h > bdsc_pkg::CFG_W'(bdsc_pkg::MAX_HEIGHT))
                 ? bdsc_pkg::CFG_W'(bdsc_pkg::MAX_HEIGHT) : r_cfg_h;
    assign out_w = w_lim[bdsc_pkg::CFG_W-1:1];
    assign out_h = h_lim[bdsc_pkg::CFG_W-1:1];

    // Position of the current pixel inside the block grid
    assign col_half = r_col[bdsc_pkg::POS_W-1:1];
    assign row_half = r_row[bdsc_pkg::POS_W-1:1];
    assign in_range = ({1'b0, col_half} < out_w) && ({1'b0, row_half} < out_h);
    assign is_done  = ({1'b0, row_half} == out_h - bdsc_pkg::POS_W'(1))
                   && ({1'b0, col_half} == out_w - bdsc_pkg::POS_W'(1));

    assign pix  = i_s_tdata[bdsc_pkg::PIX_W-1:0];
    assign pair = {1'b0, r_held} + {1'b0, pix};

    // Even rows store the pair sum, odd rows fetch it
    always_comb begin
        lb_req.wr_en   = accept && in_range && r_col[0] && !r_row[0];
        lb_req.rd_en   = accept && in_range && r_col[0] && r_row[0];
        lb_req.addr    = col_half;
        lb_req.wr_data = pair;
    end

    bdsc_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_req     (lb_req),
        .o_rd_data (lb_rd_data)
    );

    // Raster counters, wrapping per row and per frame
    assign col_wrap = ({1'b0, r_col} + bdsc_pkg::CFG_W'(1)) >= w_lim;
    assign row_wrap = ({1'b0, r_row} + bdsc_pkg::CFG_W'(1)) >= h_lim;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + bdsc_pkg::POS_W'(1);
        end else begin
            n_col = r_col + bdsc_pkg::POS_W'(1);
        end
    end

    // Configuration registers and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bdsc_pkg::RST_SOURCE_WIDTH;
            r_cfg_h <= bdsc_pkg::RST_SOURCE_HEIGHT;
            r_row   <= '0;
            r_col   <= '0;
            r_held  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bdsc_pkg::CFG_SOURCE_WIDTH:  r_cfg_w <= i_cfg_data;
                    bdsc_pkg::CFG_SOURCE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
                if (in_range && !r_col[0]) begin
                    r_held <= pix;
                end
            end
        end
    end

    // Stage 1: waits for the line buffer read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= lb_req.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lb_req.rd_en) begin
            r_s1_pair <= pair;
            r_s1_row  <= row_half;
            r_s1_col  <= col_half;
            r_s1_done <= is_done;
        end
    end

    // Output register: four-pixel sum divided by four
    assign total = {1'b0, lb_rd_data} + {1'b0, r_s1_pair};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_avg  <= total[bdsc_pkg::TOT_W-1:2];
            r_out_row  <= r_s1_row;
            r_out_col  <= r_s1_col;
            r_out_done <= r_s1_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_col, r_out_row, r_out_avg};
    assign o_m_tlast  = r_out_done;

endmodule

// File: src/bdsc_line_buf.sv
module bdsc_line_buf (
    input  logic                           i_clk,
    input  bdsc_pkg::t_lb_req              i_req,
    output logic [bdsc_pkg::SUM_W-1:0]     o_rd_data
);

    // Pair sums of the last even source row
    logic [bdsc_pkg::SUM_W-1:0] r_mem [bdsc_pkg::LINE_DEPTH];
    logic [bdsc_pkg::SUM_W-1:0] r_rd_data;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/bdsc_checker.sv
module bdsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [bdsc_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input logic                                o_m_tlast
);

    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // An empty output never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // A fresh result follows an accepted item, through stage 1 and the output register
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result without accepted input item");

endmodule

bind box_downscale_by_two_unit bdsc_checker u_bdsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: verif/bdsc_block_avg_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the 2x2 box downscaler,
// predicts each block average from its own copy of the raster state, and
// compares every accepted result with the oldest prediction.
module bdsc_block_avg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Register writes
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [bdsc_pkg::CFG_W-1:0]        i_cfg_data,
    // Pixel channel
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [bdsc_pkg::IN_DATA_W-1:0]    i_s_tdata,   // [7:0] pixel_value
    // Result channel
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] average_value, [17:8] out_row, [27:18] out_column, [31:28] zero
    input  logic [bdsc_pkg::OUT_DATA_W-1:0]   i_m_tdata,
    input  logic                              i_m_tlast,   // frame_done
    // Status for the top
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_averages_seen
);

    localparam int BLOCK_PIXELS = 4;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [bdsc_pkg::PIX_W-1:0]   average;
        logic [bdsc_pkg::COORD_W-1:0] out_row;
        logic [bdsc_pkg::COORD_W-1:0] out_col;
        logic                         frame_done;
    } t_block_avg;

    // Predicted averages still owed by the block, oldest first
    t_block_avg avg_due_q[$];

    // Own copy of the block's registers and raster state
    logic [bdsc_pkg::CFG_W-1:0] src_width;
    logic [bdsc_pkg::CFG_W-1:0] src_height;
    int unsigned                row_pos;
    int unsigned                col_pos;
    logic [bdsc_pkg::PIX_W-1:0] left_pixel;
    logic [bdsc_pkg::SUM_W-1:0] pair_sum_line [bdsc_pkg::LINE_DEPTH];

    // Advance the raster by one pixel; queue an average on each odd/odd pixel
    task automatic step_raster(input logic [bdsc_pkg::PIX_W-1:0] pix);
        int unsigned                w;
        int unsigned                h;
        int unsigned                out_w;
        int unsigned                out_h;
        logic [bdsc_pkg::IDX_W-1:0] line_idx;
        int unsigned                pair;
        int unsigned                total;
        t_block_avg                 avg;
        w = (src_width > bdsc_pkg::MAX_WIDTH) ? bdsc_pkg::MAX_WIDTH : src_width;
        h = (src_height > bdsc_pkg::MAX_HEIGHT) ? bdsc_pkg::MAX_HEIGHT : src_height;
        out_w = w / 2;
        out_h = h / 2;
        if ((col_pos / 2) < out_w && (row_pos / 2) < out_h) begin
            if (col_pos % 2 == 0) begin
                left_pixel = pix;
            end else begin
                pair = left_pixel + pix;
                line_idx = bdsc_pkg::IDX_W'(col_pos / 2);
                if (row_pos % 2 == 0) begin
                    pair_sum_line[line_idx] = bdsc_pkg::SUM_W'(pair);
                end else begin
                    total = pair_sum_line[line_idx] + pair;
                    avg.average    = bdsc_pkg::PIX_W'(total / BLOCK_PIXELS);
                    avg.out_row    = bdsc_pkg::COORD_W'(row_pos / 2);
                    avg.out_col    = bdsc_pkg::COORD_W'(line_idx);
                    avg.frame_done = (row_pos / 2 == out_h - 1)
                                  && (line_idx == out_w - 1);
                    avg_due_q.push_back(avg);
                end
            end
        end
        // counters wrap at the frame's edges, also when already beyond them
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic note_field(input string name, input logic [bdsc_pkg::COORD_W-1:0] due,
                              input logic [bdsc_pkg::COORD_W-1:0] got);
        if (got !== due) begin
            if (o_mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, due, got);
            o_mismatches++;
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_average();
        t_block_avg seen;
        t_block_avg due;
        seen.average    = i_m_tdata[bdsc_pkg::PIX_W-1:0];
        seen.out_row    = i_m_tdata[bdsc_pkg::PIX_W +: bdsc_pkg::COORD_W];
        seen.out_col    = i_m_tdata[bdsc_pkg::PIX_W+bdsc_pkg::COORD_W +: bdsc_pkg::COORD_W];
        seen.frame_done = i_m_tlast;
        o_averages_seen++;
        if (avg_due_q.size() == 0) begin
            if (o_mismatches < REPORT_LIMIT)
                $display("%0t: unexpected result: expected none, actual avg %0d row %0d col %0d",
                         $time, seen.average, seen.out_row, seen.out_col);
            o_mismatches++;
        end else begin
            due = avg_due_q.pop_front();
            note_field("average_value", bdsc_pkg::COORD_W'(due.average),
                       bdsc_pkg::COORD_W'(seen.average));
            note_field("out_row", due.out_row, seen.out_row);
            note_field("out_column", due.out_col, seen.out_col);
            note_field("frame_done", bdsc_pkg::COORD_W'(due.frame_done),
                       bdsc_pkg::COORD_W'(seen.frame_done));
        end
    endtask

    // Everything is sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_width       = bdsc_pkg::RST_SOURCE_WIDTH;
            src_height      = bdsc_pkg::RST_SOURCE_HEIGHT;
            row_pos         = 0;
            col_pos         = 0;
            left_pixel      = '0;
            o_mismatches    = 0;
            o_averages_seen = 0;
            avg_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bdsc_pkg::CFG_SOURCE_WIDTH)
                    src_width = i_cfg_data;
                else
                    src_height = i_cfg_data;
            end
            // a result accepted now never stems from the pixel accepted now
            if (i_m_tvalid && i_m_tready)
                check_average();
            if (i_s_tvalid && i_s_tready)
                step_raster(i_s_tdata[bdsc_pkg::PIX_W-1:0]);
        end
        o_pending = avg_due_q.size();
    end

endmodule

// File: verif/box_downscale_by_two_unit_tb.sv
`timescale 1ns / 100ps

module box_downscale_by_two_unit_tb;

    localparam int RANDOM_PIXELS = 900;
    localparam int STALL_LIMIT   = 2000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_index;
    logic [bdsc_pkg::CFG_W-1:0]      i_cfg_data;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [bdsc_pkg::IN_DATA_W-1:0]  i_s_tdata;    // [7:0] pixel_value
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    // [7:0] average_value, [17:8] out_row, [27:18] out_column, [31:28] zero
    logic [bdsc_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;    // frame_done

    int avg_mismatches;
    int avg_pending;
    int avg_seen;
    int pixels_sent;
    int settings_used;
    int idle_cycles;
    bit src_quiet;
    bit sink_quiet;

    box_downscale_by_two_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    bdsc_block_avg_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .o_mismatches    (avg_mismatches),
        .o_pending       (avg_pending),
        .o_averages_seen (avg_seen)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: too long without any item moving ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result receiver: random stall before each item, with quiet stretches
    initial begin : result_sink
        int unsigned stall;
        i_m_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 63) == 0)
                sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Pixel values lean toward the extremes now and then
    function automatic logic [bdsc_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return bdsc_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Pixels in one frame: oversized dimensions clamp, zero counts as one
    function automatic int unsigned frame_pixels(input int unsigned w, input int unsigned h);
        int unsigned ew;
        int unsigned eh;
        ew = (w > bdsc_pkg::MAX_WIDTH) ? bdsc_pkg::MAX_WIDTH : ((w == 0) ? 1 : w);
        eh = (h > bdsc_pkg::MAX_HEIGHT) ? bdsc_pkg::MAX_HEIGHT : ((h == 0) ? 1 : h);
        return ew * eh;
    endfunction

    task automatic send_pixel(input logic [bdsc_pkg::PIX_W-1:0] pix);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            src_quiet = !src_quiet;
        gap = src_quiet ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_tready);
        pixels_sent++;
    endtask

    task automatic send_frame(input int unsigned count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    // Stop sending, let every owed result out, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (avg_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [bdsc_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        drain();
        write_reg(bdsc_pkg::CFG_SOURCE_WIDTH, bdsc_pkg::CFG_W'(w));
        write_reg(bdsc_pkg::CFG_SOURCE_HEIGHT, bdsc_pkg::CFG_W'(h));
        settings_used++;
    endtask

    // Back to frame start from anywhere: with a frame of 0 or 1 in each dimension
    // one pixel wraps both counters and no block is formed, so no line entry is read
    task automatic realign();
        set_frame($urandom_range(0, 1), $urandom_range(0, 1));
        send_pixel(rand_pixel());
    endtask

    initial begin : stimulus
        logic [bdsc_pkg::PIX_W-1:0] corner_pixels [25];
        int unsigned                w;
        int unsigned                h;
        int unsigned                kind;
        int unsigned                rand_goal;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = bdsc_pkg::CFG_SOURCE_WIDTH;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size: one row and a bit at 352 wide gives exactly one block
        send_frame(354);
        realign();

        // Directed: saturated and empty blocks, rounding down, then 3x3
        // where the odd last column and row are dropped
        corner_pixels = '{
            8'd255, 8'd255, 8'd0,   8'd0,
            8'd255, 8'd254, 8'd0,   8'd1,
            8'd0,   8'd255, 8'd128, 8'd127,
            8'd255, 8'd0,   8'd127, 8'd128,
            8'd10,  8'd20,  8'd200,
            8'd30,  8'd40,  8'd210,
            8'd250, 8'd251, 8'd252
        };
        set_frame(4, 4);
        for (int i = 0; i < 16; i++) send_pixel(corner_pixels[i]);
        set_frame(3, 3);
        for (int i = 16; i < 25; i++) send_pixel(corner_pixels[i]);

        // Random frames, mostly small
        rand_goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < rand_goal) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 8);
                set_frame(w, h);
                repeat ($urandom_range(1, 2)) send_frame(frame_pixels(w, h));
            end else if (kind == 7) begin
                // frame cut short, then a mid-frame size change
                w = $urandom_range(2, 12);
                h = $urandom_range(2, 8);
                set_frame(w, h);
                send_frame($urandom_range(1, frame_pixels(w, h)));
                realign();
            end else if (kind == 8) begin
                // oversized dimension against a degenerate one
                w = $urandom_range(bdsc_pkg::MAX_WIDTH, 4095);
                h = $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    set_frame(h, w);
                else
                    set_frame(w, h);
                send_frame($urandom_range(1, 40));
                realign();
            end else begin
                w = $urandom_range(13, 64);
                h = $urandom_range(2, 6);
                set_frame(w, h);
                send_frame(frame_pixels(w, h));
            end
        end

        // Largest sizes, cut short: oversized width, the tallest frame, then oversized height
        set_frame(4095, 2);
        send_frame(200);
        realign();
        set_frame(2, bdsc_pkg::MAX_HEIGHT);
        send_frame(200);
        realign();
        set_frame(0, 4095);
        send_frame(5);
        realign();

        drain();
        repeat (16) @(negedge i_clk);

        $display("%0d pixels sent under %0d frame settings (sizes 0 to 4095, cut frames)",
                 pixels_sent, settings_used);
        $display("%0d block averages checked, %0d mismatches", avg_seen, avg_mismatches);
        if (avg_mismatches == 0 && avg_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
